FILE: hw/rtl/http_chunked_body_decoder_assert.svh
// Assertion macros shared by the chunked body decoder checks.
// Needs nothing else; each macro takes a label, clock, reset and two expressions.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, switched off while reset is low
`define HCBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is low
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/hcbd_pkg.sv
// Package for the chunked body decoder: word types, phase and status codes,
// byte classifiers. Depends on nothing.
`default_nettype none

package hcbd_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_LEAD     = 3'd0,
        PH_HEX      = 3'd1,
        PH_LEAD_CR  = 3'd2,
        PH_HEX_CR   = 3'd3,
        PH_DATA     = 3'd4,
        PH_TRAIL_CR = 3'd5,
        PH_TRAIL_LF = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_MORE     = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_AFTER    = 2'd2,
        ST_ERROR    = 2'd3
    } status_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        status_t     status;
        logic [31:0] total_size;
    } out_word_t;

    // True for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
            || (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Digit value; meaningful only where is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39)
            v = b - 8'h30;
        else if (b <= 8'h46)
            v = b - 8'h37;
        else
            v = b - 8'h57;
        return v[3:0];
    endfunction

    // Space, TAB, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hcbd_core.sv
// Decoder state and the single-pass step logic for one input word.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_core #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire hcbd_pkg::in_word_t  word,
    output hcbd_pkg::out_word_t      result
);

    hcbd_pkg::phase_t         phase_reg, phase_next;
    logic [LENGTH_BITS-1:0]   chunk_reg, chunk_next;
    logic [LENGTH_BITS-1:0]   body_reg, body_next;
    logic [LENGTH_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]   chunk_dec;
    logic [LENGTH_BITS-1:0]   total_sum;
    logic                     ended_reg, ended_next;
    logic                     last_reg, last_next;
    logic                     error_reg, error_next;
    logic [7:0]               b;
    hcbd_pkg::phase_t         line_phase;
    logic                     line_lf;

    assign b         = word.data_byte;
    assign chunk_dec = chunk_reg - LENGTH_BITS'(1);
    assign total_sum = body_next + chunk_next;

    // Size-line phase that a non-LF byte falls back to
    always_comb
    begin
        if (phase_reg == hcbd_pkg::PH_LEAD || phase_reg == hcbd_pkg::PH_LEAD_CR)
            line_phase = hcbd_pkg::PH_LEAD;
        else
            line_phase = hcbd_pkg::PH_HEX;
        line_lf = (phase_reg == hcbd_pkg::PH_LEAD_CR || phase_reg == hcbd_pkg::PH_HEX_CR)
            && b == hcbd_pkg::CH_LF;
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        body_next  = body_reg;
        acc_next   = acc_reg;
        ended_next = ended_reg;
        last_next  = last_reg;
        error_next = error_reg;
        if (!word.action)
        begin
            phase_next = hcbd_pkg::PH_LEAD;
            chunk_next = '0;
            body_next  = '0;
            acc_next   = '0;
            ended_next = 1'b0;
            last_next  = 1'b0;
            error_next = 1'b0;
        end
        else if (!error_reg)
        begin
            case (phase_reg)
                hcbd_pkg::PH_LEAD, hcbd_pkg::PH_HEX,
                hcbd_pkg::PH_LEAD_CR, hcbd_pkg::PH_HEX_CR:
                begin
                    if (line_lf)
                    begin
                        // End of size line: check the total still fits
                        if (acc_reg > ~body_reg)
                            error_next = 1'b1;
                        else
                        begin
                            acc_next   = '0;
                            ended_next = 1'b0;
                            if (acc_reg == '0)
                            begin
                                last_next  = 1'b1;
                                phase_next = hcbd_pkg::PH_TRAIL_CR;
                            end
                            else
                            begin
                                chunk_next = acc_reg;
                                phase_next = hcbd_pkg::PH_DATA;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = line_phase;
                        if (b == hcbd_pkg::CH_NUL)
                            error_next = 1'b1;
                        else if (line_phase == hcbd_pkg::PH_LEAD)
                        begin
                            // Skip blanks before the first digit
                            if (b == hcbd_pkg::CH_CR)
                                phase_next = hcbd_pkg::PH_LEAD_CR;
                            else if (!hcbd_pkg::is_blank(b))
                            begin
                                phase_next = hcbd_pkg::PH_HEX;
                                if (hcbd_pkg::is_hex(b))
                                    acc_next = LENGTH_BITS'(hcbd_pkg::hex_val(b));
                                else
                                    ended_next = 1'b1;
                            end
                        end
                        else if (b == hcbd_pkg::CH_CR)
                        begin
                            ended_next = 1'b1;
                            phase_next = hcbd_pkg::PH_HEX_CR;
                        end
                        else if (!ended_reg)
                        begin
                            // Accumulate digits, flagging overflow; drop text after them
                            if (!hcbd_pkg::is_hex(b))
                                ended_next = 1'b1;
                            else if (acc_reg[LENGTH_BITS-1 -: 4] != 4'd0)
                                error_next = 1'b1;
                            else
                                acc_next = {acc_reg[LENGTH_BITS-5:0], hcbd_pkg::hex_val(b)};
                        end
                    end
                end
                hcbd_pkg::PH_DATA:
                begin
                    body_next  = body_reg + LENGTH_BITS'(1);
                    chunk_next = chunk_dec;
                    if (chunk_dec == '0)
                        phase_next = hcbd_pkg::PH_TRAIL_CR;
                end
                hcbd_pkg::PH_TRAIL_CR:
                begin
                    if (b != hcbd_pkg::CH_CR)
                        error_next = 1'b1;
                    else
                        phase_next = hcbd_pkg::PH_TRAIL_LF;
                end
                hcbd_pkg::PH_TRAIL_LF:
                begin
                    if (b != hcbd_pkg::CH_LF)
                        error_next = 1'b1;
                    else if (last_reg)
                        phase_next = hcbd_pkg::PH_DONE;
                    else
                        phase_next = hcbd_pkg::PH_LEAD;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result word
    always_comb
    begin
        result.payload_valid  = word.action && !error_reg && phase_reg == hcbd_pkg::PH_DATA;
        result.payload_byte   = result.payload_valid ? b : 8'd0;
        result.payload_offset = result.payload_valid ? 32'(body_reg) : 32'd0;
        result.total_size     = 32'(total_sum);
        if (!word.action)
            result.status = hcbd_pkg::ST_MORE;
        else if (error_next)
            result.status = hcbd_pkg::ST_ERROR;
        else if (phase_reg == hcbd_pkg::PH_TRAIL_LF && last_reg)
            result.status = hcbd_pkg::ST_COMPLETE;
        else if (phase_reg == hcbd_pkg::PH_DONE)
            result.status = hcbd_pkg::ST_AFTER;
        else
            result.status = hcbd_pkg::ST_MORE;
    end

    // Advance state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_LEAD;
            chunk_reg <= '0;
            body_reg  <= '0;
            acc_reg   <= '0;
            ended_reg <= 1'b0;
            last_reg  <= 1'b0;
            error_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            body_reg  <= body_next;
            acc_reg   <= acc_next;
            ended_reg <= ended_next;
            last_reg  <= last_next;
            error_reg <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: one received byte per word in, one result word
// out per byte, at one word per clock when the output side keeps up. A word is held
// in the input register, is decoded against the state in a single pass and lands
// in the output register. Throughput is set by the output register: it refills
// in the same cycle it is taken.
// Top level: input and output registers around hcbd_core. Depends on hcbd_pkg.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire hcbd_pkg::in_word_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output hcbd_pkg::out_word_t      result
);

    logic                 in_valid_reg;
    hcbd_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg;
    hcbd_pkg::out_word_t  out_word_reg;
    hcbd_pkg::out_word_t  step_result;
    logic                 advance;

    // Move a word forward when the output register is free or being taken
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    hcbd_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .result (step_result)
    );

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_word_reg <= item;
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= step_result;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_assert.svh.
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_ready,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire hcbd_pkg::out_word_t  result
);

    logic stalled;
    logic idle_payload;

    assign stalled      = result_valid && !result_ready;
    assign idle_payload = result.payload_byte == 8'd0 && result.payload_offset == 32'd0;

    // A stalled result word holds
    `HCBD_ASSERT_NEXT(a_result_hold, clk, rst_n, stalled, result_valid && $stable(result))

    // Input backpressure only comes from a stalled output
    `HCBD_ASSERT_IMPLY(a_ready_cause, clk, rst_n, !item_ready, stalled)

    // Payload bytes never carry completion or error
    `HCBD_ASSERT_IMPLY(a_payload_status, clk, rst_n, result_valid && result.payload_valid,
        result.status == hcbd_pkg::ST_MORE)

    // Non-payload words have zero byte and offset
    `HCBD_ASSERT_IMPLY(a_idle_zero, clk, rst_n, result_valid && !result.payload_valid,
        idle_payload)

endmodule

bind http_chunked_body_decoder hcbd_checker u_checker (.*);

`default_nettype wire
